// ----- rtl/pox_pkg.sv -----
`timescale 1ns / 1ps

package pox_pkg;

  localparam int MaxCities = 64;
  localparam int CityW     = 6;
  localparam int LenW      = 7;
  localparam int OffW      = 5;
  localparam int PAddrW    = 3;

  localparam logic [LenW-1:0] TourLengthReset = 7'd64;
  localparam logic [LenW-1:0] MinLength       = 7'd2;

  // register index, taken from the word address
  localparam logic REG_TOUR_LENGTH = 1'b0;

  localparam logic [1:0] MODE_LOAD_A = 2'd0;
  localparam logic [1:0] MODE_LOAD_B = 2'd1;
  localparam logic [1:0] MODE_RUN    = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FLUSH
  } state_e;

endpackage

// ----- rtl/permutation_order_crossover.sv -----
`timescale 1ns / 1ps

// Order crossover engine. Load transactions (mode 0 for parent A, mode 1 for
// parent B) write one city per cycle, while the engine is idle, into two
// single-port RAMs and return no result. A run transaction (mode 2) emits up
// to tour_length child cities, with tour_length clamped to 2..64: first
// tour_length/2 cities of A from start_offset on (saturated to half minus
// one), then the cities of B, in order, not yet in the child, tracked in a
// 64-bit taken map cleared at the start of the run. The walk issues one RAM
// read per cycle while the output is not stalled; the RAM read is registered,
// and a one-entry hold stage decides the last flag. A new transaction is
// taken once the final result of a run has moved into the output register,
// where it may still wait to be handed off.
module permutation_order_crossover #(
  parameter int MAX_CITIES = pox_pkg::MaxCities
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pox_pkg::PAddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  mode_i,
  input  logic [5:0]                  position_i,
  input  logic [5:0]                  city_i,
  input  logic [4:0]                  start_offset_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [5:0]                  child_city_o,
  output logic [5:0]                  child_position_o,
  output logic                        last_o
);

  localparam int AW     = $clog2(MAX_CITIES);
  localparam int PW     = (AW > pox_pkg::CityW) ? AW : pox_pkg::CityW;
  localparam int LenCap = (MAX_CITIES < 64) ? MAX_CITIES : 64;
  localparam int LW     = pox_pkg::LenW;
  localparam int CW     = pox_pkg::CityW;

  pox_pkg::state_e state_q, state_d;

  logic [LW-1:0] tour_length_q;
  logic [LW-1:0] len_q;
  logic [CW-1:0] half_q;
  logic [4:0]    off_q;
  logic [LW-1:0] f_q;
  logic          fb_q;
  logic          rv_q;
  logic          rb_q;
  logic [LW-1:0] n_q;
  logic [63:0]   map_q;
  logic          pend_v_q;
  logic [CW-1:0] pend_city_q;
  logic [CW-1:0] pend_pos_q;
  logic          out_valid_q;
  logic [CW-1:0] out_city_q;
  logic [CW-1:0] out_pos_q;
  logic          out_last_q;

  logic [CW-1:0] mem_a [MAX_CITIES];
  logic [CW-1:0] mem_b [MAX_CITIES];
  logic [CW-1:0] rd_a_q;
  logic [CW-1:0] rd_b_q;

  // configuration port
  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == pox_pkg::REG_TOUR_LENGTH);
  assign prdata = (paddr[2] == pox_pkg::REG_TOUR_LENGTH) ? 32'(tour_length_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tour_length_q <= pox_pkg::TourLengthReset;
    end else if (cfg_we) begin
      tour_length_q <= pwdata[LW-1:0];
    end
  end

  // run setup from the current register and the run transaction
  logic [LW-1:0] len_c;
  logic [CW-1:0] half_c;
  logic [4:0]    off_c;
  always_comb begin
    if (tour_length_q < pox_pkg::MinLength) begin
      len_c = pox_pkg::MinLength;
    end else if (32'(tour_length_q) > LenCap) begin
      len_c = LW'(LenCap);
    end else begin
      len_c = tour_length_q;
    end
    half_c = len_c[LW-1:1];
    if (6'(start_offset_i) > half_c - 6'd1) begin
      off_c = 5'(half_c - 6'd1);
    end else begin
      off_c = start_offset_i;
    end
  end

  logic in_acc, run_acc, load_ok;
  logic [PW-1:0] pos_ext;
  assign in_ready_o = (state_q == pox_pkg::S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign run_acc    = in_acc && (mode_i == pox_pkg::MODE_RUN);
  assign pos_ext    = PW'(position_i);
  assign load_ok    = (32'(position_i) < MAX_CITIES);

  // walk control
  logic [CW-1:0] rd_city;
  logic          taken, emit, out_free, consume, push_out, flush_out;
  logic          fetch_more, hit_len, issue, walk_done;
  logic [CW-1:0] faddr;
  logic [PW-1:0] faddr_ext;

  always_comb begin
    rd_city    = rb_q ? rd_b_q : rd_a_q;
    taken      = map_q[rd_city];
    emit       = rv_q && (!rb_q || !taken);
    out_free   = !out_valid_q || out_ready_i;
    consume    = (state_q == pox_pkg::S_RUN) && rv_q && (!emit || !pend_v_q || out_free);
    push_out   = consume && emit && pend_v_q;
    flush_out  = (state_q == pox_pkg::S_FLUSH) && out_free;
    hit_len    = consume && emit && (LW'(n_q + 7'd1) == len_q);
    fetch_more = !(fb_q && (f_q == len_q));
    issue      = (state_q == pox_pkg::S_RUN) && fetch_more && (!rv_q || consume) && !hit_len;
    walk_done  = hit_len || (!fetch_more && (!rv_q || consume));
    faddr      = fb_q ? f_q[CW-1:0] : CW'(6'(off_q) + f_q[CW-1:0]);
    faddr_ext  = PW'(faddr);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pox_pkg::S_IDLE: begin
        if (run_acc) state_d = pox_pkg::S_RUN;
      end
      pox_pkg::S_RUN: begin
        if (walk_done) state_d = pox_pkg::S_FLUSH;
      end
      pox_pkg::S_FLUSH: begin
        if (flush_out) state_d = pox_pkg::S_IDLE;
      end
      default: state_d = pox_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pox_pkg::S_IDLE;
      f_q         <= '0;
      fb_q        <= 1'b0;
      rv_q        <= 1'b0;
      rb_q        <= 1'b0;
      n_q         <= '0;
      map_q       <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (run_acc) begin
        f_q      <= '0;
        fb_q     <= 1'b0;
        rv_q     <= 1'b0;
        n_q      <= '0;
        map_q    <= '0;
        pend_v_q <= 1'b0;
      end else begin
        if (issue) begin
          rv_q <= 1'b1;
          rb_q <= fb_q;
          // switch to parent B after the last city of the A part
          if (!fb_q && (f_q + 7'd1 == 7'(half_q))) begin
            fb_q <= 1'b1;
            f_q  <= '0;
          end else begin
            f_q <= f_q + 7'd1;
          end
        end else if (consume || state_q != pox_pkg::S_RUN) begin
          rv_q <= 1'b0;
        end
        if (consume && emit) begin
          n_q            <= n_q + 7'd1;
          map_q[rd_city] <= 1'b1;
          pend_v_q       <= 1'b1;
        end else if (flush_out) begin
          pend_v_q <= 1'b0;
        end
      end
      if (push_out || flush_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_acc) begin
      len_q  <= len_c;
      half_q <= half_c;
      off_q  <= off_c;
    end
    if (consume && emit) begin
      pend_city_q <= rd_city;
      pend_pos_q  <= n_q[CW-1:0];
    end
    // hold the newest city back until the next one shows whether it is last
    if (push_out || flush_out) begin
      out_city_q <= pend_city_q;
      out_pos_q  <= pend_pos_q;
      out_last_q <= flush_out;
    end
  end

  // parent RAMs
  always_ff @(posedge clk_i) begin
    if (in_acc && load_ok && (mode_i == pox_pkg::MODE_LOAD_A)) begin
      mem_a[pos_ext[AW-1:0]] <= city_i;
    end
    if (in_acc && load_ok && (mode_i == pox_pkg::MODE_LOAD_B)) begin
      mem_b[pos_ext[AW-1:0]] <= city_i;
    end
    if (issue) begin
      rd_a_q <= mem_a[faddr_ext[AW-1:0]];
      rd_b_q <= mem_b[faddr_ext[AW-1:0]];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign child_city_o     = out_city_q;
  assign child_position_o = out_pos_q;
  assign last_o           = out_last_q;

`ifndef SYNTHESIS
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pox_pkg::S_IDLE) |-> !pend_v_q)
    else $error("held city left over in idle");

  a_map_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_acc |=> (map_q == 64'd0))
    else $error("taken map not cleared at run start");

  a_flush_has_city: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pox_pkg::S_FLUSH) |-> pend_v_q)
    else $error("run finished with no city held for the last flag");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pox_pkg::S_FLUSH) |-> (7'(pend_pos_q) < len_q))
    else $error("child position beyond tour length");
`endif

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] MODE_IGNORED = 2'd3;

  localparam int ItemTarget   = 380;
  localparam int IdleLimit    = 4000;
  localparam int DrainCycles  = 100;
  localparam int HoldCycles   = 300;
  localparam int SettleCycles = 8;
  localparam int MaxReports   = 20;

  typedef enum int {
    READY_ALWAYS,
    READY_HALF,
    READY_SPARSE,
    READY_TOGGLE
  } ready_style_e;

  typedef struct packed {
    logic [pox_pkg::CityW-1:0] city;
    logic [pox_pkg::CityW-1:0] pos;
    logic                      last;
  } child_t;

  logic                       clk_i          = 1'b0;
  logic                       rst_ni         = 1'b0;
  logic                       psel           = 1'b0;
  logic                       penable        = 1'b0;
  logic                       pwrite         = 1'b0;
  logic [pox_pkg::PAddrW-1:0] paddr          = '0;
  logic [31:0]                pwdata         = '0;
  logic [31:0]                prdata;
  logic                       pready;
  logic                       in_valid_i     = 1'b0;
  logic                       in_ready_o;
  logic [1:0]                 mode_i         = pox_pkg::MODE_LOAD_A;
  logic [5:0]                 position_i     = '0;
  logic [5:0]                 city_i         = '0;
  logic [4:0]                 start_offset_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i    = 1'b0;
  logic [5:0]                 child_city_o;
  logic [5:0]                 child_position_o;
  logic                       last_o;

  permutation_order_crossover DUT (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // mirror of the block state
  logic [pox_pkg::CityW-1:0] tour_a [pox_pkg::MaxCities];
  logic [pox_pkg::CityW-1:0] tour_b [pox_pkg::MaxCities];
  logic [pox_pkg::LenW-1:0]  tour_len_reg = pox_pkg::TourLengthReset;
  child_t                    child_q[$];

  int  mismatches       = 0;
  int  children_checked = 0;
  int  loads_sent       = 0;
  int  runs_sent        = 0;
  int  ignored_sent     = 0;
  int  settings_done    = 0;
  int  burst_left       = 0;
  int  quiet_cycles     = 0;
  bit  steady_send      = 1'b0;
  bit  stall_pending    = 1'b0;

  function automatic int active_length();
    int len;
    len = tour_len_reg;
    if (len < pox_pkg::MinLength) len = pox_pkg::MinLength;
    if (len > pox_pkg::MaxCities) len = pox_pkg::MaxCities;
    return len;
  endfunction

  function automatic void predict_children(input logic [1:0] m, input logic [5:0] p,
                                           input logic [5:0] c, input logic [4:0] o);
    int len, half, ofs, n, i;
    logic [63:0] taken;
    logic [pox_pkg::CityW-1:0] cc;
    case (m)
      pox_pkg::MODE_LOAD_A: tour_a[p] = c;
      pox_pkg::MODE_LOAD_B: tour_b[p] = c;
      pox_pkg::MODE_RUN: begin
        len = active_length();
        half = len / 2;
        ofs = o;
        if (ofs > half - 1) ofs = half - 1;
        taken = '0;
        n = 0;
        // copy a block of A, then fill from B in its order
        for (i = 0; i < half && n < len; i++) begin
          cc = tour_a[ofs + i];
          child_q.insert(child_q.size(), child_t'{cc, 6'(n), 1'b0});
          n++;
          taken[cc] = 1'b1;
        end
        for (i = 0; i < len && n < len; i++) begin
          cc = tour_b[i];
          if (!taken[cc]) begin
            child_q.insert(child_q.size(), child_t'{cc, 6'(n), 1'b0});
            n++;
            taken[cc] = 1'b1;
          end
        end
        child_q[$].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < MaxReports)
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // enter and leave at a falling edge; valid stays high for back-to-back transactions
  task automatic send_item(input logic [1:0] m, input logic [5:0] p,
                           input logic [5:0] c, input logic [4:0] o);
    int gap;
    gap = 0;
    if (!steady_send) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      burst_left--;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= m;
    position_i     <= p;
    city_i         <= c;
    start_offset_i <= o;
    do @(posedge clk_i); while (!in_ready_o);
    predict_children(m, p, c, o);
    if (m == MODE_IGNORED) ignored_sent++;
    else if (m == pox_pkg::MODE_RUN) runs_sent++;
    else loads_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_for_idle();
    in_valid_i <= 1'b0;
    while (child_q.size() != 0) @(negedge clk_i);
    // loads leave nothing to wait for, so let the block settle before going on
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_tour_length(input logic [pox_pkg::LenW-1:0] value);
    wait_for_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= pox_pkg::PAddrW'({pox_pkg::REG_TOUR_LENGTH, 2'b00});
    pwdata  <= {25'($urandom), value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tour_len_reg = value;
    settings_done++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_crossover(input logic [4:0] o);
    send_item(pox_pkg::MODE_RUN, 6'($urandom), 6'($urandom), o);
  endtask

  // both parents become permutations of the same random set of cities
  task automatic load_fresh_tours(input int len);
    logic [5:0] pool [64];
    logic [5:0] t;
    int i, j;
    for (i = 0; i < 64; i++) pool[i] = 6'(i);
    for (i = 63; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = pool[i];
      pool[i] = pool[j];
      pool[j] = t;
    end
    for (i = 0; i < len; i++) send_item(pox_pkg::MODE_LOAD_A, 6'(i), pool[i], 5'($urandom));
    for (i = len - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = pool[i];
      pool[i] = pool[j];
      pool[j] = t;
    end
    for (i = 0; i < len; i++) send_item(pox_pkg::MODE_LOAD_B, 6'(i), pool[i], 5'($urandom));
  endtask

  task automatic edit_tours(input int len);
    int pick, i, j;
    logic [5:0] ci, cj;
    pick = $urandom_range(0, 9);
    i = $urandom_range(0, len - 1);
    j = $urandom_range(0, len - 1);
    if (pick < 4) begin
      // swap keeps A a permutation
      ci = tour_a[i];
      cj = tour_a[j];
      send_item(pox_pkg::MODE_LOAD_A, 6'(i), cj, 5'($urandom));
      send_item(pox_pkg::MODE_LOAD_A, 6'(j), ci, 5'($urandom));
    end else if (pick < 7) begin
      ci = tour_b[i];
      cj = tour_b[j];
      send_item(pox_pkg::MODE_LOAD_B, 6'(i), cj, 5'($urandom));
      send_item(pox_pkg::MODE_LOAD_B, 6'(j), ci, 5'($urandom));
    end else if (pick < 9) begin
      send_item($urandom_range(0, 1) ? pox_pkg::MODE_LOAD_B : pox_pkg::MODE_LOAD_A,
                6'($urandom), 6'($urandom), 5'($urandom));
    end else begin
      send_item(MODE_IGNORED, 6'($urandom), 6'($urandom), 5'($urandom));
    end
  endtask

  task automatic test_short_tours();
    write_tour_length(7'd4);
    send_item(pox_pkg::MODE_LOAD_A, 6'd0, 6'd63, 5'd0);
    send_item(pox_pkg::MODE_LOAD_A, 6'd1, 6'd0, 5'd31);
    send_item(pox_pkg::MODE_LOAD_A, 6'd2, 6'd17, 5'd0);
    send_item(pox_pkg::MODE_LOAD_A, 6'd3, 6'd42, 5'd0);
    send_item(pox_pkg::MODE_LOAD_B, 6'd3, 6'd63, 5'd0);
    send_item(pox_pkg::MODE_LOAD_B, 6'd2, 6'd0, 5'd0);
    send_item(pox_pkg::MODE_LOAD_B, 6'd1, 6'd17, 5'd0);
    send_item(pox_pkg::MODE_LOAD_B, 6'd0, 6'd42, 5'd0);
    run_crossover(5'd0);
    run_crossover(5'd31);
    send_item(MODE_IGNORED, 6'd63, 6'd63, 5'd31);
    send_item(pox_pkg::MODE_LOAD_A, 6'd63, 6'd0, 5'd0);
    send_item(pox_pkg::MODE_LOAD_B, 6'd63, 6'd63, 5'd0);
    run_crossover(5'd1);
  endtask

  task automatic test_length_floor();
    write_tour_length(7'd0);
    run_crossover(5'd31);
    write_tour_length(7'd1);
    run_crossover(5'd0);
  endtask

  task automatic test_odd_length();
    write_tour_length(7'd3);
    run_crossover(5'd31);
  endtask

  task automatic test_repeated_cities();
    write_tour_length(7'd4);
    send_item(pox_pkg::MODE_LOAD_A, 6'd1, 6'd63, 5'd0);
    run_crossover(5'd0);
    // B now mostly repeats A, so the child comes out short
    send_item(pox_pkg::MODE_LOAD_B, 6'd0, 6'd63, 5'd0);
    send_item(pox_pkg::MODE_LOAD_B, 6'd1, 6'd63, 5'd0);
    run_crossover(5'd0);
  endtask

  task automatic test_output_backpressure();
    int k;
    write_tour_length(7'd127);
    load_fresh_tours(active_length());
    steady_send   = 1'b1;
    stall_pending = 1'b1;
    for (k = 0; k < 3; k++) run_crossover(5'($urandom));
    steady_send = 1'b0;
  endtask

  task automatic test_random_tours();
    int len, runs, k, r;
    // full-size tours are already loaded
    write_tour_length(pox_pkg::TourLengthReset);
    run_crossover(5'd0);
    run_crossover(5'($urandom));
    while (loads_sent + runs_sent < ItemTarget) begin
      r = $urandom_range(0, 9);
      if (r == 0) write_tour_length(7'($urandom_range(65, 127)));
      else if (r == 1) write_tour_length(7'($urandom_range(0, 1)));
      else write_tour_length(7'($urandom_range(2, 16)));
      len = active_length();
      load_fresh_tours(len);
      runs = $urandom_range(2, 5);
      for (k = 0; k < runs; k++) begin
        repeat ($urandom_range(0, 3)) edit_tours(len);
        run_crossover(5'($urandom));
      end
    end
  endtask

  initial begin : receiver
    ready_style_e style;
    int seg_left, held;
    style = READY_ALWAYS;
    seg_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_pending) begin
        stall_pending = 1'b0;
        out_ready_i <= 1'b0;
        held = 0;
        while (held < HoldCycles) begin
          @(negedge clk_i);
          held++;
        end
      end
      if (seg_left == 0) begin
        style = ready_style_e'($urandom_range(0, 3));
        seg_left = $urandom_range(1, 40);
      end
      seg_left--;
      case (style)
        READY_ALWAYS: out_ready_i <= 1'b1;
        READY_HALF:   out_ready_i <= 1'($urandom_range(0, 1));
        READY_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
        default:      out_ready_i <= seg_left[1];
      endcase
    end
  end

  always @(posedge clk_i) begin : check_children
    child_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (child_q.size() == 0) begin
        report_mismatch("child city with nothing pending", child_city_o, 0);
      end else begin
        want = child_q.pop_front();
        if (child_city_o !== want.city)
          report_mismatch("child_city", child_city_o, want.city);
        if (child_position_o !== want.pos)
          report_mismatch("child_position", child_position_o, want.pos);
        if (last_o !== want.last)
          report_mismatch("last", last_o, want.last);
        children_checked++;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable)) begin
      quiet_cycles = 0;
    end else if (rst_ni) begin
      quiet_cycles++;
      if (quiet_cycles >= IdleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_short_tours();
    test_length_floor();
    test_odd_length();
    test_repeated_cities();
    test_output_backpressure();
    test_random_tours();
    wait_for_idle();
    repeat (DrainCycles) @(negedge clk_i);
    if (child_q.size() != 0) report_mismatch("child cities never emitted", 0, child_q.size());
    $display("covered %0d parent loads, %0d crossover runs, %0d ignored transactions",
             loads_sent, runs_sent, ignored_sent);
    $display("over %0d tour length settings; %0d child cities checked, %0d mismatches",
             settings_done, children_checked, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
